>>> sv/gptbm_pkg.sv
// ----------------------------------------------------------------------------
// gptbm_pkg
// Types and constants shared by the page-table bump mapper files.
// ----------------------------------------------------------------------------
package gptbm_pkg;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PHYS_W     = 40;
  localparam int unsigned BYTES_W    = 32;
  localparam int unsigned LOOK_W     = 32;
  localparam int unsigned GA_W       = 32;
  localparam int unsigned ENTRY_W    = 39;
  localparam int unsigned FRAME_W    = 27;  // physical bits 38:12
  localparam int unsigned PAGES_W    = 21;  // page count 0 .. 2^20
  localparam int unsigned LIDX_W     = 20;  // lookup page index

  typedef enum logic [2:0] {
    ACT_MAP      = 3'd0,
    ACT_PERM_MAP = 3'd1,
    ACT_CLEAR    = 3'd2,
    ACT_RESET    = 3'd3,
    ACT_LOOKUP   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ADDR  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_WRITE = 2'd1,
    S_READ  = 2'd2,
    S_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    status_e         status;
    logic [GA_W-1:0] ga;
    logic            hit;    // lookup entry has been written
  } result_t;

endpackage

>>> sv/gptbm_table.sv
// ----------------------------------------------------------------------------
// gptbm_table
// Page-table store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gptbm_table #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 27
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gptbm_ctrl.sv
// ----------------------------------------------------------------------------
// gptbm_ctrl
// Sequencer: decodes a word, keeps the page pointers and the fill mark,
// and steps the table writes of a map one page per cycle.
// ----------------------------------------------------------------------------
module gptbm_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned FIRST_PAGE    = 0,
  parameter int unsigned AW            = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic [gptbm_pkg::PHYS_W-1:0]  phys_address_i,
  input  logic [gptbm_pkg::BYTES_W-1:0] region_bytes_i,
  input  logic [gptbm_pkg::LOOK_W-1:0]  lookup_address_i,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [gptbm_pkg::FRAME_W-1:0] mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  output logic                          res_valid_o,
  output gptbm_pkg::result_t            res_o,
  input  logic                          res_take_i
);
  import gptbm_pkg::*;

  localparam int unsigned PMAX = (FIRST_PAGE > TABLE_ENTRIES) ? FIRST_PAGE : TABLE_ENTRIES;
  localparam int unsigned PW   = $clog2(PMAX + 1);
  localparam int unsigned CW   = ((PW > PAGES_W) ? PW : PAGES_W) + 1;

  state_e state_q, state_d;

  logic [PW-1:0]      start_q, start_d;
  logic [PW-1:0]      next_q, next_d;
  logic [PW-1:0]      hwm_q, hwm_d;    // entries FIRST_PAGE .. hwm-1 have been written
  logic [PW-1:0]      wp_q, wp_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [PAGES_W-1:0] rem_q, rem_d;
  result_t            res_q, res_d;

  logic               accept;
  action_e            act;
  logic [PW-1:0]      base;
  logic [BYTES_W:0]   bytes_up;
  logic [PAGES_W-1:0] pages;
  logic [CW-1:0]      end_page;
  logic [PW-1:0]      new_next;
  logic               fits;
  logic               addr_ok;
  logic [LIDX_W-1:0]  lidx;
  logic               lk_in;
  logic               lk_hit;
  logic [PW+11:0]     ga_full;
  logic               go_write;
  logic               go_read;

  assign accept   = in_valid_i && !in_stall_o;
  assign act      = action_e'(action_i);
  assign base     = (act == ACT_PERM_MAP) ? start_q : next_q;
  assign bytes_up = {1'b0, region_bytes_i} + (BYTES_W+1)'(12'hFFF);
  assign pages    = bytes_up[BYTES_W:PAGE_SHIFT];
  assign end_page = CW'(base) + CW'(pages);
  assign fits     = end_page <= CW'(TABLE_ENTRIES);
  assign new_next = end_page[PW-1:0];
  assign addr_ok  = !phys_address_i[PHYS_W-1];
  assign ga_full  = {base, 12'h000};
  assign lidx     = lookup_address_i[LOOK_W-1:PAGE_SHIFT];
  assign lk_in    = CW'(lidx) < CW'(TABLE_ENTRIES);
  assign lk_hit   = (CW'(lidx) >= CW'(FIRST_PAGE)) && (CW'(lidx) < CW'(hwm_q));

  // datapath and pointer updates
  always_comb begin
    start_d  = start_q;
    next_d   = next_q;
    hwm_d    = hwm_q;
    wp_d     = wp_q;
    frame_d  = frame_q;
    rem_d    = rem_q;
    res_d    = res_q;
    go_write = 1'b0;
    go_read  = 1'b0;
    if (accept) begin
      res_d.status = ST_OK;
      res_d.ga     = '0;
      res_d.hit    = 1'b0;
      unique case (act)
        ACT_MAP, ACT_PERM_MAP: begin
          next_d = base;  // permanent map rewinds first
          if (!addr_ok) begin
            res_d.status = ST_ADDR;
          end else if (!fits) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.ga = GA_W'(ga_full);
            next_d   = new_next;
            if (act == ACT_PERM_MAP) begin
              start_d = new_next;
            end
            if (new_next > hwm_q) begin
              hwm_d = new_next;
            end
            wp_d     = base;
            frame_d  = phys_address_i[ENTRY_W-1:PAGE_SHIFT];
            rem_d    = pages;
            go_write = (pages != '0);
          end
        end
        ACT_CLEAR: begin
          next_d = start_q;
        end
        ACT_RESET: begin
          start_d = PW'(FIRST_PAGE);
          next_d  = PW'(FIRST_PAGE);
        end
        ACT_LOOKUP: begin
          if (lk_in) begin
            res_d.hit = lk_hit;
            go_read   = 1'b1;
          end else begin
            res_d.status = ST_RANGE;
          end
        end
        default: ;
      endcase
    end else if (state_q == S_WRITE) begin
      wp_d    = wp_q + PW'(1);
      frame_d = frame_q + FRAME_W'(1);
      rem_d   = rem_q - PAGES_W'(1);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (go_write) begin
            state_d = S_WRITE;
          end else if (go_read) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WRITE: begin
        if (rem_q == PAGES_W'(1)) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    mem_we_o    = (state_q == S_WRITE);
    mem_re_o    = accept && go_read;
    res_valid_o = (state_q == S_DONE);
  end

  assign mem_waddr_o = wp_q[AW-1:0];
  assign mem_wdata_o = frame_q;
  assign mem_raddr_o = lidx[AW-1:0];
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= PW'(FIRST_PAGE);
      next_q  <= PW'(FIRST_PAGE);
      hwm_q   <= PW'(FIRST_PAGE);
    end else begin
      state_q <= state_d;
      start_q <= start_d;
      next_q  <= next_d;
      hwm_q   <= hwm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wp_q    <= wp_d;
    frame_q <= frame_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
  end

endmodule

>>> sv/gpu_page_table_bump_mapper_core.sv
// A word is processed to completion before the next is taken: a map writes its
// pages, a lookup reads the table, and the next word is accepted only after the
// result has moved into the output register, which an output stall can hold off.
// The table has one write port, so a map writes one entry per cycle.
// Reset sets both page pointers to FIRST_PAGE; the table is not swept:
// entries above the fill mark read as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// gpu_page_table_bump_mapper_core
// Bump allocator over a graphics page table with map, permanent map, clear, reset and lookup.
// ----------------------------------------------------------------------------
module gpu_page_table_bump_mapper_core #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned FIRST_PAGE    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic [gptbm_pkg::PHYS_W-1:0]  phys_address_i,
  input  logic [gptbm_pkg::BYTES_W-1:0] region_bytes_i,
  input  logic [gptbm_pkg::LOOK_W-1:0]  lookup_address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [gptbm_pkg::GA_W-1:0]    graphics_address_o,
  output logic [gptbm_pkg::ENTRY_W-1:0] entry_address_o
);
  import gptbm_pkg::*;

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [FRAME_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [FRAME_W-1:0] mem_rdata;
  logic               res_valid;
  result_t            res;
  logic               out_free;
  logic               res_take;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         status_q;
  logic [GA_W-1:0]    ga_q;
  logic [ENTRY_W-1:0] entry_q;

  gptbm_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FIRST_PAGE    (FIRST_PAGE),
    .AW            (AW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .phys_address_i   (phys_address_i),
    .region_bytes_i   (region_bytes_i),
    .lookup_address_i (lookup_address_i),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .res_valid_o      (res_valid),
    .res_o            (res),
    .res_take_i       (res_take)
  );

  gptbm_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW),
    .DW    (FRAME_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output word register
  assign out_free = !out_valid_q || !out_stall_i;
  assign res_take = res_valid && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      status_q <= res.status;
      ga_q     <= res.ga;
      entry_q  <= res.hit ? {mem_rdata, 12'h000} : '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign graphics_address_o = ga_q;
  assign entry_address_o    = entry_q;

endmodule

>>> verif/tb_gpu_page_table_bump_mapper_core.sv
// ----------------------------------------------------------------------------
// tb_gpu_page_table_bump_mapper_core
// Self-checking bench for the page-table bump mapper. Words are driven with
// random gaps and results taken with random stalls. A shadow table and page
// pointers predict status, graphics address and looked-up entry for each
// accepted word, and every result is checked in order against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gpu_page_table_bump_mapper_core;
  import gptbm_pkg::*;

  localparam int unsigned TABLE_PAGES     = 4096;
  localparam int unsigned BASE_PAGE       = 0;
  localparam int unsigned RANDOM_WORDS    = 1000;
  localparam int unsigned MAX_GAP         = 16;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam logic [PHYS_W-1:0] PHYS_LIMIT = 40'h7F_FFFF_FFFF;
  // action codes past lookup are ignored by the block, which still returns a result
  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    status_e            status;
    logic [GA_W-1:0]    ga;
    logic [ENTRY_W-1:0] entry;
  } answer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [2:0]          action_i;
  logic [PHYS_W-1:0]   phys_address_i;
  logic [BYTES_W-1:0]  region_bytes_i;
  logic [LOOK_W-1:0]   lookup_address_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          status_o;
  logic [GA_W-1:0]     graphics_address_o;
  logic [ENTRY_W-1:0]  entry_address_o;

  logic [PHYS_W-1:0]   tbl_shadow [TABLE_PAGES];
  int unsigned         start_shadow;
  int unsigned         next_shadow;
  answer_t             answers_due [$];
  int unsigned         mismatches;
  int unsigned         cycle_count;
  int unsigned         hold_left;
  int unsigned         pressure_left;
  bit                  no_idle;

  gpu_page_table_bump_mapper_core #(
    .TABLE_ENTRIES(TABLE_PAGES),
    .FIRST_PAGE   (BASE_PAGE)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .phys_address_i    (phys_address_i),
    .region_bytes_i    (region_bytes_i),
    .lookup_address_i  (lookup_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .graphics_address_o(graphics_address_o),
    .entry_address_o   (entry_address_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_gpu_page_table_bump_mapper_core NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (pressure_left > 0) pressure_left <= pressure_left - 1;
  end

  // Shadow of the mapper: updates table and pointers, queues the answer.
  task automatic predict_answer(input logic [2:0] act, input logic [PHYS_W-1:0] phys,
                                input logic [BYTES_W-1:0] nbytes,
                                input logic [LOOK_W-1:0] look);
    answer_t           ans;
    logic [BYTES_W:0]  rounded;
    int unsigned       pages;
    int unsigned       i;
    logic [LIDX_W-1:0] idx;
    ans     = '{status: ST_OK, ga: '0, entry: '0};
    rounded = {1'b0, nbytes} + (33'd1 << PAGE_SHIFT) - 33'd1;
    pages   = 32'(rounded >> PAGE_SHIFT);
    idx     = LIDX_W'(look >> PAGE_SHIFT);
    if (act == ACT_PERM_MAP || act == ACT_CLEAR) next_shadow = start_shadow;
    if (act == ACT_RESET) begin
      start_shadow = BASE_PAGE;
      next_shadow  = BASE_PAGE;
    end
    if (act == ACT_MAP || act == ACT_PERM_MAP) begin
      if (phys > PHYS_LIMIT) begin
        ans.status = ST_ADDR;
      end else if (next_shadow + pages > TABLE_PAGES) begin
        ans.status = ST_FULL;
      end else begin
        // low address bits are kept and bit 0 is set; lookups read only the frame bits
        for (i = 0; i < pages; i++)
          tbl_shadow[next_shadow + i] = (phys + (PHYS_W'(i) << PAGE_SHIFT)) | PHYS_W'(1);
        ans.ga = GA_W'(next_shadow << PAGE_SHIFT);
        next_shadow += pages;
        if (act == ACT_PERM_MAP) start_shadow = next_shadow;
      end
    end
    if (act == ACT_LOOKUP) begin
      if (idx < TABLE_PAGES)
        ans.entry = {tbl_shadow[idx][ENTRY_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
      else
        ans.status = ST_RANGE;
    end
    answers_due.push_back(ans);
  endtask

  task automatic send_word(input logic [2:0] act, input logic [PHYS_W-1:0] phys,
                           input logic [BYTES_W-1:0] nbytes, input logic [LOOK_W-1:0] look);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    phys_address_i   <= phys;
    region_bytes_i   <= nbytes;
    lookup_address_i <= look;
    do @(posedge clk_i); while (in_stall_o);
    predict_answer(act, phys, nbytes, look);
  endtask

  function automatic logic [PHYS_W-1:0] pick_phys();
    if ($urandom_range(0, 9) == 0) return {8'($urandom), 32'($urandom)};
    return {1'b0, 7'($urandom), 32'($urandom)};
  endfunction

  // result checking and output stall
  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result word: status %0d ga %h entry %h",
                   status_o, graphics_address_o, entry_address_o);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (status_o !== want.status || graphics_address_o !== want.ga ||
            entry_address_o !== want.entry) begin
          if (mismatches < 10)
            $display("result mismatch: expected status %0d ga %h entry %h, got %0d %h %h",
                     want.status, want.ga, want.entry,
                     status_o, graphics_address_o, entry_address_o);
          mismatches++;
        end
      end
      hold_left = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    end
    out_stall_i <= (pressure_left != 0) || (hold_left != 0);
    if (hold_left > 0) hold_left--;
  end

  task automatic test_lookup_edges();
    send_word(ACT_LOOKUP, '0, '0, 32'h0000_0000);
    send_word(ACT_LOOKUP, '0, '0, 32'h00FF_FFFF);  // last entry
    send_word(ACT_LOOKUP, '0, '0, 32'h0100_0000);  // one past the table
    send_word(ACT_LOOKUP, '1, '1, 32'hFFFF_FFFF);
  endtask

  task automatic test_map_errors();
    send_word(ACT_MAP, '0, 32'd0, '0);  // empty region
    send_word(ACT_MAP, 40'h80_0000_0000, 32'd1, '0);
    send_word(ACT_MAP, 40'hFF_FFFF_FFFF, 32'd1, '0);
    send_word(ACT_MAP, '0, 32'hFFFF_FFFF, '0);
    // top valid address, unaligned, three pages: later entries spill into bit 39
    send_word(ACT_MAP, PHYS_LIMIT, 32'h0000_2001, '0);
    send_word(ACT_LOOKUP, '0, '0, 32'h0000_1ABC);
    send_word(ACT_LOOKUP, '0, '0, 32'h0000_2000);
  endtask

  task automatic test_pointer_actions();
    send_word(ACT_PERM_MAP, 40'h12_3456_7000, 32'h0000_1000, '0);
    send_word(ACT_MAP, 40'h00_0000_8000, 32'h0000_1800, '0);
    send_word(ACT_CLEAR, '1, '1, '1);
    send_word(ACT_MAP, 40'h55_5555_5555, 32'd1, '0);
    send_word(ACT_LOOKUP, '0, '0, 32'h0000_1000);
    send_word(ACT_PERM_MAP, 40'hC0_0000_0000, 32'd1, '0);  // rewinds, then fails
    send_word(ACT_SPARE_FIRST, '1, '1, '1);
    send_word(ACT_SPARE_LAST, '1, '1, '1);
    send_word(ACT_RESET, '0, '0, '0);
    send_word(ACT_LOOKUP, '0, '0, 32'h0000_0000);  // table survives reset action
  endtask

  task automatic test_table_fill();
    send_word(ACT_MAP, 40'h01_0000_0000, 32'h0100_0000, '0);  // fills exactly
    send_word(ACT_MAP, '0, 32'd1, '0);
    send_word(ACT_MAP, '0, 32'd0, '0);
    send_word(ACT_LOOKUP, '0, '0, 32'h00FF_F123);
    send_word(ACT_PERM_MAP, '0, 32'd0, '0);
    send_word(ACT_RESET, '0, '0, '0);
  endtask

  // receiver held off while the sender keeps offering words
  task automatic test_stall_fill();
    int unsigned n;
    pressure_left <= PRESSURE_CYCLES;
    no_idle = 1'b1;
    for (n = 0; n < 30; n++) begin
      if (n % 3 == 2)
        send_word(ACT_LOOKUP, pick_phys(), $urandom, (n << PAGE_SHIFT) | $urandom_range(0, 4095));
      else
        send_word(ACT_MAP, pick_phys(), $urandom_range(0, 3 << PAGE_SHIFT), $urandom);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    int unsigned pick;
    int unsigned pg;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      no_idle = (n >= 300 && n < 400);
      pick    = $urandom_range(0, 99);
      pg      = $urandom_range(0, next_shadow + 8);
      if (pick < 45)
        send_word(ACT_MAP, pick_phys(), $urandom_range(0, 16 << PAGE_SHIFT), $urandom);
      else if (pick < 53)
        send_word(ACT_PERM_MAP, pick_phys(), $urandom_range(0, 8 << PAGE_SHIFT), $urandom);
      else if (pick < 58)
        send_word(ACT_CLEAR, pick_phys(), $urandom, $urandom);
      else if (pick < 61)
        send_word(ACT_RESET, pick_phys(), $urandom, $urandom);
      else if (pick < 85)
        send_word(ACT_LOOKUP, pick_phys(), $urandom,
                  LOOK_W'(pg << PAGE_SHIFT) | $urandom_range(0, 4095));
      else if (pick < 90)
        send_word(ACT_LOOKUP, pick_phys(), $urandom, $urandom);
      else if (pick < 93)
        send_word(ACT_MAP, pick_phys(), $urandom_range(0, TABLE_PAGES << PAGE_SHIFT), $urandom);
      else if (pick < 96)
        send_word(ACT_MAP, {8'($urandom), 32'($urandom)}, $urandom, $urandom);
      else if (pick < 98)
        send_word(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), pick_phys(), $urandom,
                  $urandom);
      else
        send_word(ACT_PERM_MAP, pick_phys(), $urandom, $urandom);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    action_i         <= ACT_MAP;
    phys_address_i   <= '0;
    region_bytes_i   <= '0;
    lookup_address_i <= '0;
    out_stall_i      <= 1'b0;
    mismatches    = 0;
    cycle_count   = 0;
    hold_left     = 0;
    pressure_left = 0;
    no_idle       = 1'b0;
    foreach (tbl_shadow[k]) tbl_shadow[k] = '0;
    start_shadow = BASE_PAGE;
    next_shadow  = BASE_PAGE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_lookup_edges();
    test_map_errors();
    test_pointer_actions();
    test_table_fill();
    test_stall_fill();
    test_random_traffic();
    in_valid_i <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_gpu_page_table_bump_mapper_core OK");
    else
      $display("tb_gpu_page_table_bump_mapper_core NOT OK");
    $finish;
  end

endmodule
